FILE: hw/rtl/pwl_pkg.sv
// Shared types and codes for the piecewise linear interpolator.
// Holds the command and response words and the divider request/response structs.
// No dependencies.
package pwl_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] STATUS_WRITE = 2'd0;
	localparam logic [1:0] STATUS_VALID = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam int NUM_W = 34;
	localparam int DEN_W = 17;
	localparam int MAG_W = 33;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic               operation;
		logic [4:0]         entry_index;
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
	} pwl_cmd_t;

	typedef struct packed {
		logic signed [15:0] y_result;
		logic [1:0]         status;
	} pwl_rsp_t;

	typedef struct packed {
		logic                   start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} pwl_div_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [NUM_W-1:0] quo;
	} pwl_div_rsp_t;

endpackage

FILE: hw/rtl/pwl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module pwl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/pwl_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pwl_pkg for the request and response structs.
module pwl_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwl_pkg::pwl_div_req_t req,
	output pwl_pkg::pwl_div_rsp_t rsp
);
	import pwl_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 sign_q;
	logic [MAG_W-1:0]     qn_q;
	logic [DEN_W-2:0]     rem_q;
	logic [DEN_W-2:0]     dmag_q;

	logic signed [NUM_W-1:0] num_neg;
	logic signed [DEN_W-1:0] den_neg;
	logic [DEN_W-1:0]        rem_sh;
	logic                    fits;
	logic [NUM_W-1:0]        qext;

	assign num_neg = -req.num;
	assign den_neg = -req.den;
	assign rem_sh  = {rem_q, qn_q[MAG_W-1]};
	assign fits    = rem_sh >= {1'b0, dmag_q};
	assign qext    = {1'b0, qn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sign_q <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
			qn_q   <= req.num[NUM_W-1] ? num_neg[MAG_W-1:0] : req.num[MAG_W-1:0];
			dmag_q <= req.den[DEN_W-1] ? den_neg[DEN_W-2:0] : req.den[DEN_W-2:0];
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (DEN_W-1)'(rem_sh - {1'b0, dmag_q}) : rem_sh[DEN_W-2:0];
			qn_q  <= {qn_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sign_q ? NUM_W'(-qext) : qext;

endmodule

FILE: hw/rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: breakpoint memory, search sequencer,
// multiplier and output register. Depends on pwl_pkg, pwl_ram and pwl_div.
//
// A write word stores one (x, y) breakpoint and answers from S_FIN through the output
// register. A query word reads the first and last breakpoints in use, then
// binary-searches the table in memory, each probe being one synchronous read (S_SEARCH)
// and one compare (S_PROBE), about log2(entries_in_use - 1) probes, four or five for
// 32 entries. Exact breakpoint hits and zero-width segments answer after the search;
// other queries add a multiply state, a divider start state and a 33-step bit-serial
// divide. The next word is taken once the answer has moved into the output register.
// One word is in flight at a time, and the next is taken while the previous answer
// waits in the output register.
// Breakpoints have no reset value and must be written before queries reach them; the
// table should be ascending in x over the entries in use.
module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  pwl_pkg::pwl_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pwl_pkg::pwl_rsp_t rsp
);
	import pwl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = (CW > 6) ? CW : 6;
	localparam int EW = (CW > 5) ? CW : 5;
	localparam logic signed [34:0] SAT_HI = 35'sd32767;
	localparam logic signed [34:0] SAT_LO = -35'sd32768;

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_LAST, S_SEARCH, S_PROBE, S_EVAL, S_MUL, S_DIVST, S_DIV, S_FIN
	} state_t;

	state_t   state_q;
	logic [5:0] entries_q;
	logic     rsp_valid_q;
	pwl_rsp_t rsp_q;

	logic signed [15:0] xq_q, xl_q, yl_q, xu_q, yu_q;
	logic [AW-1:0]      lo_q, hi_q, mid_q;
	logic signed [16:0] dx_q, dy_q, den_q;
	logic signed [33:0] prod_q;
	logic signed [15:0] res_y_q;
	logic [1:0]         res_st_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      raddr;
	logic [31:0]        rdata;
	logic signed [15:0] rd_x, rd_y;
	logic [NW-1:0]      n_ext, n_eff;
	logic [AW-1:0]      last_idx;
	logic [AW:0]        mid_sum;
	logic [AW:0]        span;
	logic               out_free;
	logic signed [34:0] sum;
	pwl_div_req_t       div_req;
	pwl_div_rsp_t       div_rsp;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign ram_we    = accept && (cmd.operation == OP_WRITE)
		&& (EW'(cmd.entry_index) < EW'(TABLE_DEPTH));
	assign rd_x      = rdata[31:16];
	assign rd_y      = rdata[15:0];
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign span      = {1'b0, hi_q} - {1'b0, lo_q};
	assign n_ext     = NW'(entries_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (n_ext < NW'(2)) begin
			n_eff = NW'(2);
		end else if (n_ext > NW'(TABLE_DEPTH)) begin
			n_eff = NW'(TABLE_DEPTH);
		end else begin
			n_eff = n_ext;
		end
	end

	assign last_idx = AW'(n_eff - 1'b1);

	always_comb begin
		unique case (state_q)
			S_FIRST:  raddr = last_idx;
			S_SEARCH: raddr = mid_sum[AW:1];
			default:  raddr = '0;
		endcase
	end

	pwl_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(cmd.entry_index)),
		.wdata({cmd.x_value, cmd.y_value}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign div_req.start = (state_q == S_DIVST);
	assign div_req.num   = prod_q;
	assign div_req.den   = den_q;

	pwl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign sum = {{19{yl_q[15]}}, yl_q} + {div_rsp.quo[33], div_rsp.quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entries_q   <= 6'd2;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cmd.operation == OP_WRITE) ? S_FIN : S_FIRST;
					end
				end
				S_FIRST: state_q <= S_LAST;
				S_LAST: begin
					if (xq_q < xl_q || xq_q > rd_x) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: state_q <= (span > (AW+1)'(1)) ? S_PROBE : S_EVAL;
				S_PROBE:  state_q <= S_SEARCH;
				S_EVAL: begin
					if (xq_q == xl_q || xq_q == xu_q || xu_q == xl_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_DIVST;
				S_DIVST: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				xq_q     <= cmd.x_value;
				res_y_q  <= '0;
				res_st_q <= STATUS_WRITE;
			end
			S_FIRST: begin
				lo_q <= '0;
				hi_q <= last_idx;
				xl_q <= rd_x;
				yl_q <= rd_y;
			end
			S_LAST: begin
				xu_q <= rd_x;
				yu_q <= rd_y;
				res_st_q <= STATUS_RANGE;
			end
			S_SEARCH: begin
				mid_q <= mid_sum[AW:1];
			end
			S_PROBE: begin
				if (xq_q < rd_x) begin
					hi_q <= mid_q;
					xu_q <= rd_x;
					yu_q <= rd_y;
				end else begin
					lo_q <= mid_q;
					xl_q <= rd_x;
					yl_q <= rd_y;
				end
			end
			S_EVAL: begin
				res_st_q <= STATUS_VALID;
				res_y_q  <= (xq_q != xl_q && xq_q == xu_q) ? yu_q : yl_q;
				dx_q     <= {xq_q[15], xq_q} - {xl_q[15], xl_q};
				dy_q     <= {yu_q[15], yu_q} - {yl_q[15], yl_q};
				den_q    <= {xu_q[15], xu_q} - {xl_q[15], xl_q};
			end
			S_MUL: begin
				prod_q <= dx_q * dy_q;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (sum > SAT_HI) begin
						res_y_q <= 16'sh7FFF;
					end else if (sum < SAT_LO) begin
						res_y_q <= -16'sh8000;
					end else begin
						res_y_q <= sum[15:0];
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					rsp_q.y_result <= res_y_q;
					rsp_q.status   <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
